FILE: rtl/core/text_console_writer_top_macros.svh
// assertion macros shared by the text console writer rtl
// expects aclk and aresetn in the scope of each use
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// property holds at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TCW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcw_pkg.sv
// text console writer package: field widths, codes and control structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int LOC_W    = 11;
    localparam int CELL_W   = 16;
    localparam int TDATA_W  = 32;
    localparam int M_PAD_W  = TDATA_W - LOC_W - CELL_W;

    // input word bit offsets
    localparam int S_CMD_LSB  = 0;
    localparam int S_CHAR_LSB = S_CMD_LSB + CMD_W;
    localparam int S_FORE_LSB = S_CHAR_LSB + CHAR_W;
    localparam int S_BACK_LSB = S_FORE_LSB + COLOR_W;
    localparam int S_RROW_LSB = S_BACK_LSB + COLOR_W;
    localparam int S_RCOL_LSB = S_RROW_LSB + RROW_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic put_wr;
        logic sweep_wr;
        logic newline;
        logic cr;
        logic clear;
        logic rd_issue;
        logic out_load;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_put;
        logic is_read;
        logic is_clear;
        logic ch_nl;
        logic ch_cr;
        logic row_valid;
        logic sweep_last;
        logic tab_last;
        logic out_free;
    } tcw_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_ctrl.sv
// text console writer controller state machine
// depends on tcw_pkg and text_console_writer_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_top_macros.svh"

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire tcw_status_t status_i,
    output tcw_cmd_t         cmd_o
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;

    assign s_tready = s_tready_reg;

    always_comb begin
        cmd_o      = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                if (status_i.is_put) begin
                    if (status_i.ch_nl) begin
                        cmd_o.newline = 1'b1;
                    end else if (status_i.ch_cr) begin
                        cmd_o.cr = 1'b1;
                    end else begin
                        state_next = ST_PUT;
                    end
                end else if (status_i.is_read) begin
                    cmd_o.rd_issue = 1'b1;
                end else if (status_i.is_clear) begin
                    cmd_o.clear = 1'b1;
                end
            end
            ST_PUT: begin
                if (!status_i.row_valid) begin
                    state_next = ST_SWEEP;
                end else begin
                    cmd_o.put_wr = 1'b1;
                    if (status_i.tab_last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SWEEP: begin
                cmd_o.sweep_wr = 1'b1;
                if (status_i.sweep_last) begin
                    state_next = ST_PUT;
                end
            end
            ST_FINISH: begin
                if (status_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    `TCW_ASSERT_ALWAYS(a_one_action,
        ($onehot0({cmd_o.put_wr, cmd_o.sweep_wr, cmd_o.newline, cmd_o.cr,
                   cmd_o.clear, cmd_o.rd_issue})),
        "more than one datapath action in a cycle")
    `TCW_ASSERT_IMPLIES(a_sweep_only_invalid, (state_reg == ST_SWEEP),
        (!status_i.row_valid), "row sweep running on a row already blank")
    `TCW_ASSERT_NEXT(a_load_then_decode, (cmd_o.load),
        (state_reg == ST_DECODE && !s_tready), "accepted word not decoded next")

endmodule

`default_nettype wire

FILE: rtl/core/tcw_datapath.sv
// text console writer datapath: cell memory, cursor, row pointer, output register
// depends on tcw_pkg and text_console_writer_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_top_macros.svh"

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tcw_cmd_t            cmd_i,
    output tcw_status_t              status_o,
    input  wire logic [CMD_W-1:0]    cmd_in,
    input  wire logic [CHAR_W-1:0]   char_code,
    input  wire logic [COLOR_W-1:0]  fore_color,
    input  wire logic [COLOR_W-1:0]  back_color,
    input  wire logic [RROW_W-1:0]   read_row,
    input  wire logic [RCOL_W-1:0]   read_col,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [LOC_W-1:0]         cursor_pos,
    output logic [CELL_W-1:0]        read_data
);

    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int TAB_W      = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;
    localparam int LOC_CALC_W = (ADDR_W > LOC_W) ? ADDR_W : LOC_W;

    // captured item
    logic [CMD_W-1:0]   item_cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] back_reg;
    logic [RROW_W-1:0]  rrow_reg;
    logic [RCOL_W-1:0]  rcol_reg;

    // console state
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [ROWS-1:0]  row_valid_reg, row_valid_next;
    logic [COL_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [TAB_W-1:0] tab_cnt_reg, tab_cnt_next;

    // read path and output
    logic [CELL_W-1:0] cell_mem [CELLS];
    logic [CELL_W-1:0] mem_q_reg;
    logic              rd_oob_reg;
    logic              rd_blank_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [LOC_W-1:0]  loc_out_reg;
    logic [CELL_W-1:0] data_out_reg;

    logic [ROW_W:0]      cur_sum, rd_sum, top_sum;
    logic [ROW_W-1:0]    cur_phys, rd_phys, top_inc;
    logic                rd_in_range;
    logic [COL_W-1:0]    wr_col;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [CHAR_W-1:0]   put_char;
    logic [CELL_W-1:0]   wr_data;
    logic                col_last, row_last, sweep_last, go_next_row;
    logic [LOC_CALC_W-1:0] loc_full;
    logic [CELL_W-1:0]   result_data;

    // logical row to physical row through the top-row pointer
    always_comb begin
        cur_sum  = {1'b0, top_reg} + {1'b0, cur_row_reg};
        cur_phys = (cur_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(cur_sum - (ROW_W+1)'(ROWS))
                                                 : ROW_W'(cur_sum);
        rd_sum   = {1'b0, top_reg} + {1'b0, rrow_reg[ROW_W-1:0]};
        rd_phys  = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W+1)'(ROWS))
                                                : ROW_W'(rd_sum);
        top_sum  = {1'b0, top_reg} + (ROW_W+1)'(1);
        top_inc  = (top_sum >= (ROW_W+1)'(ROWS)) ? '0 : ROW_W'(top_sum);
        rd_in_range = ({1'b0, rrow_reg} < (RROW_W+1)'(ROWS)) &&
                      ({1'b0, rcol_reg} < (RCOL_W+1)'(COLUMNS));
    end

    assign sweep_last = (sweep_cnt_reg == COL_W'(COLUMNS - 1));
    assign col_last   = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign row_last   = (cur_row_reg == ROW_W'(ROWS - 1));
    assign wr_col     = cmd_i.sweep_wr ? sweep_cnt_reg : cur_col_reg;
    assign wr_addr    = ADDR_W'(cur_phys) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);
    assign rd_addr    = ADDR_W'(rd_phys) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_reg[COL_W-1:0]);
    assign put_char   = (char_reg == CHAR_NUL || char_reg == CHAR_TAB) ? CHAR_SPACE : char_reg;
    assign wr_data    = cmd_i.sweep_wr ? BLANK_CELL : {back_reg, fore_reg, put_char};
    assign go_next_row = cmd_i.newline || (cmd_i.put_wr && col_last);

    always_comb begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        sweep_cnt_next = sweep_cnt_reg;
        tab_cnt_next   = tab_cnt_reg;

        if (cmd_i.load) begin
            tab_cnt_next = (cmd_in == CMD_PUT && char_code == CHAR_TAB)
                         ? TAB_W'(TAB_SPACES - 1) : '0;
        end
        if (cmd_i.put_wr) begin
            cur_col_next = cur_col_reg + COL_W'(1);
            if (tab_cnt_reg != '0) begin
                tab_cnt_next = tab_cnt_reg - TAB_W'(1);
            end
        end
        if (go_next_row) begin
            cur_col_next = '0;
            if (row_last) begin
                // scroll: old top row becomes the blank bottom row
                top_next                = top_inc;
                row_valid_next[top_reg] = 1'b0;
            end else begin
                cur_row_next = cur_row_reg + ROW_W'(1);
            end
        end
        if (cmd_i.cr) begin
            cur_col_next = '0;
        end
        if (cmd_i.sweep_wr) begin
            sweep_cnt_next = sweep_last ? '0 : sweep_cnt_reg + COL_W'(1);
            if (sweep_last) begin
                row_valid_next[cur_phys] = 1'b1;
            end
        end
        if (cmd_i.clear) begin
            cur_col_next   = '0;
            cur_row_next   = '0;
            top_next       = '0;
            row_valid_next = '0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd_i.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign loc_full = LOC_CALC_W'(cur_row_reg) * LOC_CALC_W'(COLUMNS)
                    + LOC_CALC_W'(cur_col_reg);

    always_comb begin
        result_data = '0;
        if (item_cmd_reg == CMD_READ && !rd_oob_reg) begin
            result_data = rd_blank_reg ? BLANK_CELL : mem_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            sweep_cnt_reg <= '0;
            tab_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            sweep_cnt_reg <= sweep_cnt_next;
            tab_cnt_reg   <= tab_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            item_cmd_reg <= cmd_in;
            char_reg     <= char_code;
            fore_reg     <= fore_color;
            back_reg     <= back_color;
            rrow_reg     <= read_row;
            rcol_reg     <= read_col;
        end
        if (cmd_i.rd_issue) begin
            rd_oob_reg   <= !rd_in_range;
            rd_blank_reg <= !row_valid_reg[rd_phys];
        end
        if (cmd_i.out_load) begin
            loc_out_reg  <= loc_full[LOC_W-1:0];
            data_out_reg <= result_data;
        end
    end

    // cell memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd_i.put_wr || cmd_i.sweep_wr) begin
            cell_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.rd_issue) begin
            mem_q_reg <= cell_mem[rd_addr];
        end
    end

    always_comb begin
        status_o.is_put     = (item_cmd_reg == CMD_PUT);
        status_o.is_read    = (item_cmd_reg == CMD_READ);
        status_o.is_clear   = (item_cmd_reg == CMD_CLEAR);
        status_o.ch_nl      = (char_reg == CHAR_NL);
        status_o.ch_cr      = (char_reg == CHAR_CR);
        status_o.row_valid  = row_valid_reg[cur_phys];
        status_o.sweep_last = sweep_last;
        status_o.tab_last   = (tab_cnt_reg == '0);
        status_o.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign cursor_pos = loc_out_reg;
    assign read_data  = data_out_reg;

    `TCW_ASSERT_ALWAYS(a_cursor_in_range,
        (({1'b0, cur_col_reg} < (COL_W+1)'(COLUMNS)) &&
         ({1'b0, cur_row_reg} < (ROW_W+1)'(ROWS))),
        "cursor outside the screen")
    `TCW_ASSERT_IMPLIES(a_put_into_blanked_row, (cmd_i.put_wr),
        (row_valid_reg[cur_phys]), "character written into a row not yet blanked")
    `TCW_ASSERT_IMPLIES(a_sweep_count_owner, (sweep_cnt_reg != '0),
        ($past(cmd_i.sweep_wr)), "row sweep counter moved outside a sweep")

endmodule

`default_nettype wire

FILE: rtl/core/text_console_writer_top.sv
// text console writer top level: stream ports, controller and datapath
// depends on tcw_pkg, tcw_ctrl and tcw_datapath
`timescale 1ns / 1ps
`default_nettype none

// Text console writer. Holds a ROWS x COLUMNS screen of 16-bit cells
// (char in bits 7:0, foreground 11:8, background 15:12) and a cursor, and
// takes one command word at a time on the s_ stream: put character, read
// cell, or clear screen and home cursor. Every command word gives exactly
// one result word on the m_ stream with the linear cursor location after
// the command and, for an in-range read, the cell value (zero otherwise).
// From the accept edge to the result entering the output register, read,
// clear, newline, return and the unused code go through decode and finish;
// a printable put adds one cell write and a tab adds TAB_SPACES of them.
// The first write into a row after a clear or a scroll first blanks that
// row, one cell a cycle, since the cell memory has a single write port;
// rows are tracked by one valid bit each, so a clear only resets the valid
// bits and a scroll only moves the top-row pointer. There is no clearing
// pass after reset. A new word is taken the cycle after the previous one
// has reached the output register, even while that result is still waiting
// for m_tready.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // cmd[1:0], char_code[9:2], fore_color[13:10], back_color[17:14],
    // read_row[22:18], read_col[29:23], zero pad[31:30]
    input  wire logic [TDATA_W-1:0] s_tdata,
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // cursor_pos[10:0], read_data[26:11], zero pad[31:27]
    output logic [TDATA_W-1:0]      m_tdata
);

    tcw_cmd_t          ctrl_cmd;
    tcw_status_t       dp_status;
    logic [LOC_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_data;

    // sequencer: accept, decode, cell writes, row blanking, result hand-off
    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status_i (dp_status),
        .cmd_o    (ctrl_cmd)
    );

    // screen memory, cursor, scroll pointer and output register
    tcw_datapath #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_i      (ctrl_cmd),
        .status_o   (dp_status),
        .cmd_in     (s_tdata[S_CMD_LSB  +: CMD_W]),
        .char_code  (s_tdata[S_CHAR_LSB +: CHAR_W]),
        .fore_color (s_tdata[S_FORE_LSB +: COLOR_W]),
        .back_color (s_tdata[S_BACK_LSB +: COLOR_W]),
        .read_row   (s_tdata[S_RROW_LSB +: RROW_W]),
        .read_col   (s_tdata[S_RCOL_LSB +: RCOL_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cursor_pos (cursor_pos),
        .read_data  (read_data)
    );

    // result word packing, location in the low bits
    assign m_tdata = {{M_PAD_W{1'b0}}, read_data, cursor_pos};

endmodule

`default_nettype wire

FILE: test/text_console_writer_checker.sv
// checker for the text console writer: watches both streams, keeps its own screen
// and cursor, predicts each result word and compares it field by field
// depends on tcw_pkg
`timescale 1ns / 1ps

module text_console_writer_checker
    import tcw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    output int                      mismatch_count,
    output int                      results_pending
);

    localparam int COLS    = 80;
    localparam int ROWS    = 25;
    localparam int TAB_N   = 4;
    localparam int CELLS   = COLS * ROWS;

    typedef struct packed {
        logic [LOC_W-1:0]  loc;
        logic [CELL_W-1:0] data;
    } console_result_t;

    logic [CELL_W-1:0] screen_model [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    console_result_t   expected_results [$];
    int                mismatches;
    int                result_index;

    initial begin
        mismatches      = 0;
        result_index    = 0;
        mismatch_count  = 0;
        results_pending = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] result %0d: %s", $realtime, result_index, what);
        mismatches++;
    endtask

    function void blank_screen();
        int i;
        for (i = 0; i < CELLS; i++)
            screen_model[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function void scroll_screen();
        int i;
        for (i = 0; i + COLS < CELLS; i++)
            screen_model[i] = screen_model[i + COLS];
        for (i = CELLS - COLS; i < CELLS; i++)
            screen_model[i] = BLANK_CELL;
    endfunction

    function void row_advance();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            scroll_screen();
            cur_row = ROWS - 1;
        end
    endfunction

    function void store_char(input logic [CHAR_W-1:0] ch, input logic [7:0] attr);
        logic [CHAR_W-1:0] shown;
        shown = (ch == CHAR_NUL) ? CHAR_SPACE : ch;
        screen_model[cur_row * COLS + cur_col] = {attr, shown};
        cur_col++;
        if (cur_col >= COLS)
            row_advance();
    endfunction

    // applies one command word to the screen copy and returns the result word it causes
    function console_result_t predict_command(input logic [TDATA_W-1:0] w);
        logic [CMD_W-1:0]   cmd;
        logic [CHAR_W-1:0]  ch;
        logic [7:0]         attr;
        logic [RROW_W-1:0]  rrow;
        logic [RCOL_W-1:0]  rcol;
        console_result_t    res;
        int                 k;
        cmd  = w[S_CMD_LSB +: CMD_W];
        ch   = w[S_CHAR_LSB +: CHAR_W];
        attr = {w[S_BACK_LSB +: COLOR_W], w[S_FORE_LSB +: COLOR_W]};
        rrow = w[S_RROW_LSB +: RROW_W];
        rcol = w[S_RCOL_LSB +: RCOL_W];
        res.data = '0;
        case (cmd)
            CMD_PUT: begin
                if (ch == CHAR_TAB) begin
                    for (k = 0; k < TAB_N; k++)
                        store_char(CHAR_SPACE, attr);
                end else if (ch == CHAR_NL) begin
                    row_advance();
                end else if (ch == CHAR_CR) begin
                    cur_col = 0;
                end else begin
                    store_char(ch, attr);
                end
            end
            CMD_READ: begin
                if (rrow < ROWS && rcol < COLS)
                    res.data = screen_model[rrow * COLS + rcol];
            end
            CMD_CLEAR: blank_screen();
            default: ;
        endcase
        res.loc = LOC_W'(cur_row * COLS + cur_col);
        return res;
    endfunction

    always @(posedge aclk) begin
        console_result_t want;
        console_result_t got;
        if (!aresetn) begin
            blank_screen();
            expected_results.delete();
        end else begin
            // results first, so a word cannot match the one accepted at this edge
            if (m_tvalid && m_tready) begin
                got.loc  = m_tdata[LOC_W-1:0];
                got.data = m_tdata[LOC_W +: CELL_W];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word loc=%0d data=%h",
                                              got.loc, got.data));
                end else begin
                    want = expected_results.pop_front();
                    if (got.loc !== want.loc)
                        report_mismatch($sformatf("cursor_location %0d, expected %0d",
                                                  got.loc, want.loc));
                    if (got.data !== want.data)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  got.data, want.data));
                end
                result_index++;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_command(s_tdata));
        end
        mismatch_count  <= mismatches;
        results_pending <= expected_results.size();
    end

endmodule

FILE: test/tb_text_console_writer_top.sv
// testbench top for the text console writer: clock, reset, command stimulus,
// result back-pressure and verdict; depends on tcw_pkg, text_console_writer_top
// and text_console_writer_checker
`timescale 1ns / 1ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    // the package names no code for the spare command value
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_WORDS   = 310;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 1000000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_pending;
    int cycle_count;

    text_console_writer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // prediction and comparison live in the checker, the top only drives and judges
    text_console_writer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog: a hung block ends the run here
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side: random back-pressure, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_tready <= 1'b0;
                // counted here so the sender keeps pushing words into a full block
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // packs the command fields into a word, lowest field in the lowest bits
    function automatic logic [TDATA_W-1:0] pack_word(
        input logic [CMD_W-1:0]   cmd,
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fore,
        input logic [COLOR_W-1:0] back,
        input logic [RROW_W-1:0]  rrow,
        input logic [RCOL_W-1:0]  rcol
    );
        logic [TDATA_W-1:0] w;
        w = '0;
        w[S_CMD_LSB  +: CMD_W]   = cmd;
        w[S_CHAR_LSB +: CHAR_W]  = ch;
        w[S_FORE_LSB +: COLOR_W] = fore;
        w[S_BACK_LSB +: COLOR_W] = back;
        w[S_RROW_LSB +: RROW_W]  = rrow;
        w[S_RCOL_LSB +: RCOL_W]  = rcol;
        return w;
    endfunction

    // put with the given character, random colors and random unused read fields
    function automatic logic [TDATA_W-1:0] put_word(input logic [CHAR_W-1:0] ch);
        return pack_word(CMD_PUT, ch, COLOR_W'($urandom_range(15)),
                         COLOR_W'($urandom_range(15)), RROW_W'($urandom_range(31)),
                         RCOL_W'($urandom_range(127)));
    endfunction

    // mostly typing, with control characters, reads and the odd clear mixed in
    function automatic logic [TDATA_W-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(999);
        if (pick < 5)
            return pack_word(CMD_CLEAR, CHAR_W'($urandom_range(255)),
                             COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                             RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
        if (pick < 15)
            return pack_word(CMD_UNUSED, CHAR_W'($urandom_range(255)),
                             COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                             RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
        if (pick < 170) begin
            // reads land on the screen most of the time, sometimes anywhere
            if ($urandom_range(9) != 0)
                return pack_word(CMD_READ, CHAR_W'($urandom_range(255)),
                                 COLOR_W'($urandom_range(15)),
                                 COLOR_W'($urandom_range(15)),
                                 RROW_W'($urandom_range(24)),
                                 RCOL_W'($urandom_range(79)));
            return pack_word(CMD_READ, CHAR_W'($urandom_range(255)),
                             COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                             RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
        end
        if (pick < 290)
            return put_word(CHAR_NL);
        if (pick < 360)
            return put_word(CHAR_TAB);
        if (pick < 390)
            return put_word(CHAR_CR);
        if (pick < 405)
            return put_word(CHAR_NUL);
        return put_word(CHAR_W'($urandom_range(255)));
    endfunction

    // offers one word and returns at the edge where it is taken
    task automatic push_word(input logic [TDATA_W-1:0] w);
        int gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // sender stops until every expected result word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
    endtask

    // short directed run: field extremes, every command, every special character
    task automatic directed_words();
        push_word(pack_word(CMD_PUT, 8'h41, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_PUT, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_word(pack_word(CMD_PUT, CHAR_NUL, 4'h3, 4'h5, 5'd0, 7'd0));
        push_word(pack_word(CMD_PUT, CHAR_TAB, 4'hF, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_READ, 8'hFF, 4'hF, 4'hF, 5'd0, 7'd2));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd5));
        push_word(pack_word(CMD_PUT, CHAR_CR, 4'h0, 4'hF, 5'd0, 7'd0));
        push_word(pack_word(CMD_PUT, CHAR_NL, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_UNUSED, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd24, 7'd79));
        // reads just past the screen edges
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd0));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd80));
        push_word(pack_word(CMD_READ, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_word(pack_word(CMD_PUT, 8'h7F, 4'hA, 4'h5, 5'd0, 7'd0));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
        push_word(pack_word(CMD_CLEAR, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
        // character with its top bit set must not spill into the attribute
        push_word(pack_word(CMD_PUT, 8'h80, 4'hF, 4'hF, 5'd0, 7'd0));
        push_word(pack_word(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_PUT, CHAR_NL, 4'h0, 4'h0, 5'd0, 7'd0));
        push_word(pack_word(CMD_PUT, CHAR_TAB, 4'h1, 4'h2, 5'd0, 7'd0));
        push_word(pack_word(CMD_PUT, CHAR_TAB, 4'h2, 4'h1, 5'd0, 7'd0));
    endtask

    initial begin
        int phase;
        int n;
        int run_len;
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_off_pending = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < 3; phase++) begin
            // idle mix: sender idle 25% / receiver idle 68%, then swapped, then none
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
                directed_words();
            // long receiver hold-off while the sender keeps pushing
            if (phase == 2)
                hold_off_pending = 1'b1;
            n = 0;
            while (n < PHASE_WORDS) begin
                if ($urandom_range(99) < 2) begin
                    // burst of newlines to walk the cursor down and scroll
                    run_len = $urandom_range(10, 30);
                    repeat (run_len) push_word(put_word(CHAR_NL));
                    n += run_len;
                end else begin
                    push_word(random_word());
                    n++;
                end
            end
            drain_results();
        end

        // let any stray result words show up before judging
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
